// File: hw/rtl/bst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bst_pkg: shared types and constants of the bencode stream tokenizer
// Byte codes, event and error codes, and the word carried from the front
// end to the back end.
// ---------------------------------------------------------------------------
package bst_pkg;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDict  = 8'h64;
  localparam logic [7:0] ChList  = 8'h6c;
  localparam logic [7:0] ChInt   = 8'h69;
  localparam logic [7:0] ChEnd   = 8'h65;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChMinus = 8'h2d;

  localparam logic [3:0] EvNone     = 4'd0;
  localparam logic [3:0] EvListOpen = 4'd1;
  localparam logic [3:0] EvDictOpen = 4'd2;
  localparam logic [3:0] EvClose    = 4'd3;
  localparam logic [3:0] EvInteger  = 4'd4;
  localparam logic [3:0] EvEmptyStr = 4'd5;
  localparam logic [3:0] EvStrStart = 4'd6;
  localparam logic [3:0] EvStrByte  = 4'd7;
  localparam logic [3:0] EvError    = 4'd8;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrBadStart  = 3'd1;
  localparam logic [2:0] ErrKeyNotStr = 3'd2;
  localparam logic [2:0] ErrBadInt    = 3'd3;
  localparam logic [2:0] ErrIntOvf    = 3'd4;
  localparam logic [2:0] ErrBadLen    = 3'd5;
  localparam logic [2:0] ErrLenLimit  = 3'd6;
  localparam logic [2:0] ErrTooDeep   = 3'd7;

  // byte class decided by the front end
  typedef enum logic [3:0] {
    CLS_DIGIT, CLS_LIST, CLS_DICT, CLS_INT, CLS_END, CLS_COLON, CLS_MINUS, CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic [7:0] data_byte;
    cls_e       cls;
    logic [3:0] digit;
  } fe_word_t;

  localparam int unsigned FeWordW = $bits(fe_word_t);

endpackage

// File: hw/rtl/bst_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bst_front: byte classifier
// Takes raw bytes and pushes them with their class into the queue.
// ---------------------------------------------------------------------------
module bst_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output bst_pkg::fe_word_t q_word_o
);

  bst_pkg::fe_word_t word_d;
  logic              valid_q;
  bst_pkg::fe_word_t word_q;

  assign in_ready_o = !valid_q || q_ready_i;

  always_comb begin
    word_d.data_byte = in_byte_i;
    word_d.digit     = 4'(in_byte_i - bst_pkg::ChZero);
    if (in_byte_i >= bst_pkg::ChZero && in_byte_i <= bst_pkg::ChNine) begin
      word_d.cls = bst_pkg::CLS_DIGIT;
    end else begin
      case (in_byte_i)
        bst_pkg::ChList:  word_d.cls = bst_pkg::CLS_LIST;
        bst_pkg::ChDict:  word_d.cls = bst_pkg::CLS_DICT;
        bst_pkg::ChInt:   word_d.cls = bst_pkg::CLS_INT;
        bst_pkg::ChEnd:   word_d.cls = bst_pkg::CLS_END;
        bst_pkg::ChColon: word_d.cls = bst_pkg::CLS_COLON;
        bst_pkg::ChMinus: word_d.cls = bst_pkg::CLS_MINUS;
        default:          word_d.cls = bst_pkg::CLS_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign q_valid_o = valid_q;
  assign q_word_o  = word_q;

endmodule

// File: hw/rtl/bst_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bst_fifo: two-entry queue
// Decouples the classifier from the parser; full rate while the parser reads.
// ---------------------------------------------------------------------------
module bst_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  bst_pkg::fe_word_t wr_word_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output bst_pkg::fe_word_t rd_word_o
);

  bst_pkg::fe_word_t mem_q [2];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_word_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_word_i;
  end

endmodule

// File: hw/rtl/bst_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bst_back: token parser
// Runs the parse state machine on classified bytes, one per cycle while the
// output is taken, and holds each token in an output register.
// ---------------------------------------------------------------------------
module bst_back #(
  parameter int unsigned MaxDepth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  bst_pkg::fe_word_t q_word_i,
  input  logic [5:0]        depth_limit_i,
  input  logic [30:0]       length_limit_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        event_res_o,
  output logic [63:0]       int_value_o,
  output logic [30:0]       string_length_o,
  output logic [7:0]        string_byte_o,
  output logic              string_last_o,
  output logic              is_key_o,
  output logic              is_text_o,
  output logic [5:0]        depth_o,
  output logic [2:0]        error_code_o
);

  localparam int unsigned LvlW = $clog2(MaxDepth + 1);
  localparam int unsigned IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam logic [62:0] MagMax = {63{1'b1}};

  typedef enum logic [2:0] {M_VALUE, M_INT, M_LEN, M_STR, M_ERR} mode_e;

  mode_e            mode_q, mode_d;
  logic [MaxDepth-1:0] kinds_q, kinds_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic             awaits_q, awaits_d;
  logic [62:0]      acc_q, acc_d;
  logic             neg_q, neg_d, seen_q, seen_d;
  logic [30:0]      rem_q, rem_d;
  logic             key_q, key_d;
  logic [1:0]       upend_q, upend_d;
  logic [2:0]       ucls_q, ucls_d;
  logic             uval_q, uval_d;
  logic [2:0]       err_q, err_d;

  logic [3:0]  ev;
  logic [63:0] ival;
  logic [30:0] slen;
  logic        slast, okey, otext;

  logic        fire, top_dict, key_pos;
  logic [7:0]  b;
  logic [3:0]  dg;
  logic [66:0] acc_x10;
  logic [34:0] rem_x10;
  logic [LvlW:0] lim;
  logic [7:0]  lo, hi;
  logic [30:0] rem_dec;

  logic        ovalid_q;

  assign q_ready_o = !ovalid_q || out_ready_i;
  assign fire      = q_valid_i && q_ready_o;
  assign b         = q_word_i.data_byte;
  assign dg        = q_word_i.digit;
  assign top_dict  = (lvl_q != '0) && kinds_q[IdxW'(lvl_q - 1'b1)];
  assign key_pos   = top_dict && !awaits_q;
  assign acc_x10   = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 67'(dg);
  assign rem_x10   = {rem_q, 3'b000} + {2'b00, rem_q, 1'b0} + 35'(dg);
  assign lim       = (32'(depth_limit_i) < MaxDepth) ? (LvlW+1)'(depth_limit_i)
                                                     : (LvlW+1)'(MaxDepth);
  assign rem_dec   = (rem_q != '0) ? rem_q - 31'd1 : rem_q;

  always_comb begin
    mode_d = mode_q; kinds_d = kinds_q; lvl_d = lvl_q; awaits_d = awaits_q;
    acc_d = acc_q; neg_d = neg_q; seen_d = seen_q; rem_d = rem_q; key_d = key_q;
    upend_d = upend_q; ucls_d = ucls_q; uval_d = uval_q; err_d = err_q;
    ev = bst_pkg::EvNone; ival = '0; slen = '0; slast = 1'b0; okey = 1'b0;
    otext = 1'b0; lo = 8'h80; hi = 8'hbf;
    case (mode_q)
      M_VALUE: begin
        if (q_word_i.cls == bst_pkg::CLS_END) begin
          if (lvl_q == '0 || (top_dict && awaits_q)) begin
            ev = bst_pkg::EvError; err_d = bst_pkg::ErrBadStart; mode_d = M_ERR;
          end else begin
            lvl_d = lvl_q - 1'b1;
            ev = bst_pkg::EvClose;
            if (lvl_d != '0 && kinds_q[IdxW'(lvl_d - 1'b1)]) awaits_d = 1'b0;
          end
        end else if (q_word_i.cls == bst_pkg::CLS_DIGIT) begin
          key_d = key_pos;
          if (31'(dg) > length_limit_i) begin
            ev = bst_pkg::EvError; err_d = bst_pkg::ErrLenLimit; mode_d = M_ERR;
          end else begin
            rem_d = 31'(dg); mode_d = M_LEN;
          end
        end else if (key_pos) begin
          ev = bst_pkg::EvError; err_d = bst_pkg::ErrKeyNotStr; mode_d = M_ERR;
        end else if (q_word_i.cls == bst_pkg::CLS_LIST || q_word_i.cls == bst_pkg::CLS_DICT) begin
          if ({1'b0, lvl_q} >= lim) begin
            ev = bst_pkg::EvError; err_d = bst_pkg::ErrTooDeep; mode_d = M_ERR;
          end else begin
            kinds_d[IdxW'(lvl_q)] = q_word_i.cls == bst_pkg::CLS_DICT;
            lvl_d = lvl_q + 1'b1;
            awaits_d = 1'b0;
            ev = (q_word_i.cls == bst_pkg::CLS_DICT) ? bst_pkg::EvDictOpen
                                                     : bst_pkg::EvListOpen;
          end
        end else if (q_word_i.cls == bst_pkg::CLS_INT) begin
          acc_d = '0; neg_d = 1'b0; seen_d = 1'b0; mode_d = M_INT;
        end else begin
          ev = bst_pkg::EvError; err_d = bst_pkg::ErrBadStart; mode_d = M_ERR;
        end
      end
      M_INT: begin
        if (q_word_i.cls == bst_pkg::CLS_DIGIT) begin
          if (acc_x10 > 67'(MagMax)) begin
            ev = bst_pkg::EvError; err_d = bst_pkg::ErrIntOvf; mode_d = M_ERR;
          end else begin
            acc_d = acc_x10[62:0]; seen_d = 1'b1;
          end
        end else if (q_word_i.cls == bst_pkg::CLS_MINUS && !seen_q && !neg_q) begin
          neg_d = 1'b1;
        end else if (q_word_i.cls == bst_pkg::CLS_END && seen_q) begin
          ev = bst_pkg::EvInteger;
          ival = neg_q ? 64'(-{1'b0, acc_q}) : {1'b0, acc_q};
          mode_d = M_VALUE;
          if (top_dict) awaits_d = 1'b0;
        end else begin
          ev = bst_pkg::EvError; err_d = bst_pkg::ErrBadInt; mode_d = M_ERR;
        end
      end
      M_LEN: begin
        if (q_word_i.cls == bst_pkg::CLS_DIGIT) begin
          if (rem_x10 > 35'(length_limit_i)) begin
            ev = bst_pkg::EvError; err_d = bst_pkg::ErrLenLimit; mode_d = M_ERR;
          end else begin
            rem_d = rem_x10[30:0];
          end
        end else if (q_word_i.cls == bst_pkg::CLS_COLON) begin
          okey = key_q;
          if (rem_q == '0) begin
            ev = bst_pkg::EvEmptyStr; mode_d = M_VALUE;
            if (top_dict) awaits_d = key_q;
          end else begin
            ev = bst_pkg::EvStrStart; slen = rem_q;
            upend_d = '0; ucls_d = '0; uval_d = 1'b1; mode_d = M_STR;
          end
        end else begin
          ev = bst_pkg::EvError; err_d = bst_pkg::ErrBadLen; mode_d = M_ERR;
        end
      end
      M_STR: begin
        ev = bst_pkg::EvStrByte; okey = key_q;
        if (upend_q != '0) begin
          case (ucls_q)
            3'd1:    lo = 8'ha0;
            3'd2:    hi = 8'h9f;
            3'd3:    lo = 8'h90;
            3'd4:    hi = 8'h8f;
            default: lo = 8'h80;
          endcase
          ucls_d = '0;
          if (b < lo || b > hi) begin
            uval_d = 1'b0; upend_d = '0;
          end else begin
            upend_d = upend_q - 2'd1;
          end
        end else begin
          ucls_d = '0;
          if (b < 8'h80) begin
            upend_d = '0;
          end else if (b >= 8'hc2 && b <= 8'hdf) begin
            upend_d = 2'd1;
          end else if (b >= 8'he0 && b <= 8'hef) begin
            upend_d = 2'd2;
            if (b == 8'he0) ucls_d = 3'd1;
            else if (b == 8'hed) ucls_d = 3'd2;
          end else if (b >= 8'hf0 && b <= 8'hf4) begin
            upend_d = 2'd3;
            if (b == 8'hf0) ucls_d = 3'd3;
            else if (b == 8'hf4) ucls_d = 3'd4;
          end else begin
            uval_d = 1'b0;
          end
        end
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          slast = 1'b1;
          otext = uval_d && upend_d == '0;
          mode_d = M_VALUE;
          if (top_dict) awaits_d = key_q;
        end
      end
      default: begin
        mode_d = M_ERR; ev = bst_pkg::EvError;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_VALUE; lvl_q <= '0; awaits_q <= 1'b0; acc_q <= '0; neg_q <= 1'b0;
      seen_q <= 1'b0; rem_q <= '0; key_q <= 1'b0; upend_q <= '0; ucls_q <= '0;
      uval_q <= 1'b1; err_q <= bst_pkg::ErrNone; ovalid_q <= 1'b0;
      kinds_q         <= '0;
      event_res_o     <= bst_pkg::EvNone;
      int_value_o     <= '0;
      string_length_o <= '0;
      string_byte_o   <= '0;
      string_last_o   <= 1'b0;
      is_key_o        <= 1'b0;
      is_text_o       <= 1'b0;
      depth_o         <= '0;
      error_code_o    <= bst_pkg::ErrNone;
    end else begin
      if (q_ready_o) ovalid_q <= q_valid_i;
      if (fire) begin
        mode_q <= mode_d; lvl_q <= lvl_d; awaits_q <= awaits_d; acc_q <= acc_d;
        neg_q <= neg_d; seen_q <= seen_d; rem_q <= rem_d; key_q <= key_d;
        upend_q <= upend_d; ucls_q <= ucls_d; uval_q <= uval_d; err_q <= err_d;
        kinds_q         <= kinds_d;
        event_res_o     <= ev;
        int_value_o     <= ival;
        string_length_o <= slen;
        string_byte_o   <= (ev == bst_pkg::EvStrByte) ? b : 8'd0;
        string_last_o   <= slast;
        is_key_o        <= okey;
        is_text_o       <= otext;
        depth_o         <= 6'(lvl_d);
        error_code_o    <= (ev == bst_pkg::EvError) ? err_d : bst_pkg::ErrNone;
      end
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// File: hw/rtl/bencode_stream_tokenizer.sv
`timescale 1ns / 1ps
// Path: an accepted byte reaches its token word through the classifier
//   register, the queue and the parser output register.
// Throughput: one byte per cycle while the master stream accepts words.
// Reset: asynchronous, active low; parser starts expecting a value, limits
//   return to 32 and 2^31-1. No clearing pass.
// ---------------------------------------------------------------------------
// bencode_stream_tokenizer: bencode byte stream to token stream
// Classifier front end, two-entry queue and parser back end.
// ---------------------------------------------------------------------------
module bencode_stream_tokenizer #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] int_value, [94:64] string_length, [102:95] string_byte,
  // [108:103] depth, [111:109] error_code
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast,   // string_last
  output logic [5:0]   m_axis_tuser,   // [3:0] event_res, [4] is_key, [5] is_text
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);

  localparam logic CfgDepth  = 1'b0;
  localparam logic CfgLength = 1'b1;

  logic [5:0]  depth_limit_q;
  logic [30:0] length_limit_q;

  logic              f_valid, f_ready, b_valid, b_ready;
  bst_pkg::fe_word_t f_word, b_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q  <= 6'd32;
      length_limit_q <= 31'h7fffffff;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDepth:  depth_limit_q  <= cfg_data_i[5:0];
        CfgLength: length_limit_q <= cfg_data_i;
        default:   depth_limit_q  <= depth_limit_q;
      endcase
    end
  end

  bst_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_byte_i(s_axis_tdata),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_word_o(f_word)
  );

  bst_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_word_i(f_word),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_word_o(b_word)
  );

  bst_back #(.MaxDepth(MAX_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_word_i(b_word),
    .depth_limit_i(depth_limit_q), .length_limit_i(length_limit_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .event_res_o(m_axis_tuser[3:0]), .int_value_o(m_axis_tdata[63:0]),
    .string_length_o(m_axis_tdata[94:64]), .string_byte_o(m_axis_tdata[102:95]),
    .string_last_o(m_axis_tlast), .is_key_o(m_axis_tuser[4]),
    .is_text_o(m_axis_tuser[5]), .depth_o(m_axis_tdata[108:103]),
    .error_code_o(m_axis_tdata[111:109])
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: bencode stream tokenizer
// Feeds bencoded bytes through the slave stream and checks every token word
// on the master stream against a cycle-free model of the tokenizer. Both
// sides idle at random. The run covers several limit settings and finally
// drives one malformed sequence to reach the sticky error state.
// ---------------------------------------------------------------------------
module testbench;

  localparam logic CfgDepthLimit  = 1'b0;
  localparam logic CfgLengthLimit = 1'b1;
  localparam int   MaxDepth       = 32;
  localparam logic [63:0] MagMax  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {MODE_VALUE, MODE_INT, MODE_LEN, MODE_STR, MODE_ERR} mode_e;

  typedef struct packed {
    logic [3:0]  ev;
    logic [63:0] ival;
    logic [30:0] slen;
    logic [7:0]  sbyte;
    logic        slast;
    logic        key;
    logic        text;
    logic [5:0]  depth;
    logic [2:0]  err;
  } token_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [5:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [30:0]  cfg_data_i = '0;

  bencode_stream_tokenizer DUT (.*);

  // tokenizer model state
  mode_e       mode;
  logic        kinds [MaxDepth];
  int unsigned nest;
  logic        awaits_value;
  logic [63:0] accum;
  logic        negative;
  logic        digit_seen;
  logic [63:0] remaining;
  logic        cur_key;
  int unsigned u8_pending;
  int unsigned u8_class;
  logic        u8_valid;
  logic [2:0]  err_kept;
  logic [63:0] depth_lim;
  logic [63:0] len_lim;

  logic [7:0] byte_q[$];
  token_t     token_q[$];
  int         fails = 0;
  int         tx_gap = 0, rx_gap = 0;
  bit         tx_burst = 0, rx_burst = 0;
  bit         sent = 0, got = 0;

  function automatic bit top_dict();
    return nest != 0 && kinds[nest-1];
  endfunction

  function automatic void close_value(logic was_key);
    mode = MODE_VALUE;
    if (top_dict()) awaits_value = was_key;
  endfunction

  function automatic logic [3:0] raise(logic [2:0] code);
    mode = MODE_ERR;
    err_kept = code;
    return bst_pkg::EvError;
  endfunction

  function automatic void utf8_step(logic [7:0] b);
    logic [7:0] lo, hi;
    if (u8_pending != 0) begin
      lo = 8'h80;
      hi = 8'hBF;
      case (u8_class)
        1: lo = 8'hA0;
        2: hi = 8'h9F;
        3: lo = 8'h90;
        4: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        u8_valid = 0;
        u8_pending = 0;
      end else begin
        u8_pending--;
      end
      u8_class = 0;
      return;
    end
    u8_class = 0;
    if (b < 8'h80) return;
    if (b >= 8'hC2 && b <= 8'hDF) u8_pending = 1;
    else if (b >= 8'hE0 && b <= 8'hEF) begin
      u8_pending = 2;
      if (b == 8'hE0) u8_class = 1;
      else if (b == 8'hED) u8_class = 2;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      u8_pending = 3;
      if (b == 8'hF0) u8_class = 3;
      else if (b == 8'hF4) u8_class = 4;
    end else u8_valid = 0;
  endfunction

  function automatic token_t tokenize(logic [7:0] b);
    token_t      t;
    bit          dig;
    logic [63:0] d;
    bit          key_pos;
    logic [63:0] lim;
    t = '0;
    dig = b >= bst_pkg::ChZero && b <= bst_pkg::ChNine;
    d = 64'(b - bst_pkg::ChZero);
    case (mode)
      MODE_VALUE: begin
        key_pos = top_dict() && !awaits_value;
        if (b == bst_pkg::ChEnd) begin
          if (nest == 0 || (top_dict() && awaits_value)) t.ev = raise(bst_pkg::ErrBadStart);
          else begin
            nest--;
            t.ev = bst_pkg::EvClose;
            close_value(0);
          end
        end else if (dig) begin
          cur_key = key_pos;
          if (d > len_lim) t.ev = raise(bst_pkg::ErrLenLimit);
          else begin
            remaining = d;
            mode = MODE_LEN;
          end
        end else if (key_pos) begin
          t.ev = raise(bst_pkg::ErrKeyNotStr);
        end else if (b == bst_pkg::ChList || b == bst_pkg::ChDict) begin
          lim = depth_lim < MaxDepth ? depth_lim : MaxDepth;
          if (nest >= lim) t.ev = raise(bst_pkg::ErrTooDeep);
          else begin
            kinds[nest] = b == bst_pkg::ChDict;
            nest++;
            awaits_value = 0;
            t.ev = b == bst_pkg::ChDict ? bst_pkg::EvDictOpen : bst_pkg::EvListOpen;
          end
        end else if (b == bst_pkg::ChInt) begin
          accum = 0;
          negative = 0;
          digit_seen = 0;
          mode = MODE_INT;
        end else t.ev = raise(bst_pkg::ErrBadStart);
      end
      MODE_INT: begin
        if (dig) begin
          if (accum > (MagMax - d) / 10) t.ev = raise(bst_pkg::ErrIntOvf);
          else begin
            accum = accum * 10 + d;
            digit_seen = 1;
          end
        end else if (b == bst_pkg::ChMinus && !digit_seen && !negative) negative = 1;
        else if (b == bst_pkg::ChEnd && digit_seen) begin
          t.ev = bst_pkg::EvInteger;
          t.ival = negative ? -accum : accum;
          close_value(0);
        end else t.ev = raise(bst_pkg::ErrBadInt);
      end
      MODE_LEN: begin
        if (dig) begin
          if (remaining > (len_lim - d) / 10 || d > len_lim)
            t.ev = raise(bst_pkg::ErrLenLimit);
          else remaining = remaining * 10 + d;
        end else if (b == bst_pkg::ChColon) begin
          t.key = cur_key;
          if (remaining == 0) begin
            t.ev = bst_pkg::EvEmptyStr;
            close_value(cur_key);
          end else begin
            t.ev = bst_pkg::EvStrStart;
            t.slen = remaining[30:0];
            u8_pending = 0;
            u8_class = 0;
            u8_valid = 1;
            mode = MODE_STR;
          end
        end else t.ev = raise(bst_pkg::ErrBadLen);
      end
      MODE_STR: begin
        t.ev = bst_pkg::EvStrByte;
        t.sbyte = b;
        t.key = cur_key;
        utf8_step(b);
        if (remaining > 0) remaining--;
        if (remaining == 0) begin
          t.slast = 1;
          t.text = u8_valid && u8_pending == 0;
          close_value(cur_key);
        end
      end
      default: begin
        mode = MODE_ERR;
        t.ev = bst_pkg::EvError;
      end
    endcase
    t.depth = nest[5:0];
    t.err = t.ev == bst_pkg::EvError ? err_kept : bst_pkg::ErrNone;
    return t;
  endfunction

  function automatic int draw_wait(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 19);
  endfunction

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // stimulus side: one word per handshake, random gaps between words
  always @(negedge clk_i) begin
    bit take;
    take = sent;
    sent = 0;
    if ($urandom_range(0, 99) == 0) tx_burst = ~tx_burst;
    if (s_axis_tvalid && !take) begin
      // hold until accepted
    end else if (tx_gap != 0) begin
      tx_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (byte_q.size() != 0) begin
      s_axis_tdata <= byte_q.pop_front();
      s_axis_tvalid <= 1'b1;
      tx_gap = draw_wait(tx_burst);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) rx_burst = ~rx_burst;
    if (got) begin
      got = 0;
      rx_gap = draw_wait(rx_burst);
    end
    if (rx_gap != 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    token_t e, a;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      token_q.push_back(tokenize(s_axis_tdata));
      sent = 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = 1;
      a.ev = m_axis_tuser[3:0];
      a.ival = m_axis_tdata[63:0];
      a.slen = m_axis_tdata[94:64];
      a.sbyte = m_axis_tdata[102:95];
      a.slast = m_axis_tlast;
      a.key = m_axis_tuser[4];
      a.text = m_axis_tuser[5];
      a.depth = m_axis_tdata[108:103];
      a.err = m_axis_tdata[111:109];
      if (token_q.size() == 0) begin
        $error("token word with none outstanding: %h", m_axis_tdata);
        fails++;
      end else begin
        e = token_q.pop_front();
        if (a.ev != e.ev) begin
          $error("event_res expected %0d actual %0d", e.ev, a.ev); fails++;
        end
        if (a.ival != e.ival) begin
          $error("int_value expected %0d actual %0d", $signed(e.ival), $signed(a.ival));
          fails++;
        end
        if (a.slen != e.slen) begin
          $error("string_length expected %0d actual %0d", e.slen, a.slen); fails++;
        end
        if (a.sbyte != e.sbyte) begin
          $error("string_byte expected %h actual %h", e.sbyte, a.sbyte); fails++;
        end
        if (a.slast != e.slast) begin
          $error("string_last expected %0d actual %0d", e.slast, a.slast); fails++;
        end
        if (a.key != e.key) begin
          $error("is_key expected %0d actual %0d", e.key, a.key); fails++;
        end
        if (a.text != e.text) begin
          $error("is_text expected %0d actual %0d", e.text, a.text); fails++;
        end
        if (a.depth != e.depth) begin
          $error("depth expected %0d actual %0d", e.depth, a.depth); fails++;
        end
        if (a.err != e.err) begin
          $error("error_code expected %0d actual %0d", e.err, a.err); fails++;
        end
      end
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic push_string(int n, bit zero_pad);
    int kind;
    if (zero_pad) byte_q.push_back(bst_pkg::ChZero);
    push_text($sformatf("%0d:", n));
    kind = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if (kind == 0) byte_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
      else if (kind == 1 && i + 1 < n && $urandom_range(0, 1)) begin
        byte_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        byte_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        i++;
      end else byte_q.push_back(8'($urandom));
    end
  endtask

  task automatic push_random_string();
    int n;
    n = $urandom_range(0, 6);
    if (n > len_lim) n = int'(len_lim);
    push_string(n, $urandom_range(0, 9) == 0);
  endtask

  task automatic push_random_int();
    int nd;
    if ($urandom_range(0, 2) == 0) push_text("i-");
    else push_text("i");
    nd = $urandom_range(0, 5) == 0 ? $urandom_range(1, 18) : $urandom_range(1, 4);
    for (int i = 0; i < nd; i++) byte_q.push_back(8'(bst_pkg::ChZero + $urandom_range(0, 9)));
    byte_q.push_back(bst_pkg::ChEnd);
  endtask

  task automatic push_random_value(int lvl);
    int pick, n;
    pick = $urandom_range(0, 3);
    if (pick >= 2 && lvl >= depth_lim) pick = $urandom_range(0, 1);
    case (pick)
      0: push_random_int();
      1: push_random_string();
      2: begin
        byte_q.push_back(bst_pkg::ChList);
        n = $urandom_range(0, lvl < 3 ? 3 : 1);
        for (int i = 0; i < n; i++) push_random_value(lvl + 1);
        byte_q.push_back(bst_pkg::ChEnd);
      end
      default: begin
        byte_q.push_back(bst_pkg::ChDict);
        n = $urandom_range(0, lvl < 3 ? 3 : 1);
        for (int i = 0; i < n; i++) begin
          push_random_string();
          push_random_value(lvl + 1);
        end
        byte_q.push_back(bst_pkg::ChEnd);
      end
    endcase
  endtask

  task automatic drain();
    wait (byte_q.size() == 0 && !s_axis_tvalid && token_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limits(logic [5:0] dl, logic [30:0] ll);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgDepthLimit;
    cfg_data_i <= 31'(dl);
    @(negedge clk_i);
    cfg_idx_i <= CfgLengthLimit;
    cfg_data_i <= ll;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    depth_lim = 64'(dl);
    len_lim = 64'(ll);
  endtask

  task automatic random_phase(int count);
    int start;
    start = byte_q.size();
    while (byte_q.size() - start < count) push_random_value(0);
    drain();
  endtask

  initial begin
    mode = MODE_VALUE;
    foreach (kinds[i]) kinds[i] = 0;
    nest = 0;
    awaits_value = 0;
    accum = 0;
    negative = 0;
    digit_seen = 0;
    remaining = 0;
    cur_key = 0;
    u8_pending = 0;
    u8_class = 0;
    u8_valid = 1;
    err_kept = bst_pkg::ErrNone;
    depth_lim = 32;
    len_lim = 64'h7FFF_FFFF;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // largest integer, minus zero and leading zeros, empty and keyed strings, edge bytes for the is_text check
    push_text("i9223372036854775807e");
    push_text("i-0ei007e");
    push_text("d1:a0:1:bleel");
    push_text("4:");
    byte_q.push_back(8'h00); byte_q.push_back(8'hFF);
    byte_q.push_back(8'hE0); byte_q.push_back(8'hA0);
    push_text("e");
    drain();

    write_limits(6'd1, 31'd0);
    push_text("lede0:d0:0:e");
    random_phase(200);
    write_limits(6'd63, 31'd9);
    random_phase(600);
    write_limits(6'd4, 31'd3);
    random_phase(300);
    write_limits(6'd32, 31'h7FFF_FFFF);
    random_phase(800);

    // one malformed sequence; the error then sticks
    case ($urandom_range(1, 7))
      1: push_text("x");
      2: push_text("di");
      3: push_text($urandom_range(0, 1) ? "i--" : "i3-");
      4: push_text("i-9223372036854775808");
      5: push_text("12x");
      6: push_text("2147483648");
      default: for (int i = 0; i <= MaxDepth; i++) byte_q.push_back(bst_pkg::ChList);
    endcase
    for (int i = 0; i < 6; i++) byte_q.push_back(8'($urandom));
    drain();
    repeat (10) @(posedge clk_i);
    if (token_q.size() != 0) fails++;
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bst_pkg.sv
hw/rtl/bst_front.sv
hw/rtl/bst_fifo.sv
hw/rtl/bst_back.sv
hw/rtl/bencode_stream_tokenizer.sv
test/testbench.sv
